>>> sv/nearest_centre_table_core_defines.svh
// Assertion macros shared by the nearest-centre table RTL.
`ifndef NEAREST_CENTRE_TABLE_CORE_DEFINES_SVH
`define NEAREST_CENTRE_TABLE_CORE_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define NCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define NCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define NCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nct_pkg.sv
// Types, codes and constants of the nearest-centre table.
package nct_pkg;

  localparam int MAX_CENTRES_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  // Wide enough for any table position or count up to 2047 entries
  localparam int SEL_W        = 11;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int TARGET_W     = 6;
  localparam int DRAIN_W      = 2;
  // Distance pipeline depth after the last feed cycle, minus one
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

  // Register index taken from the word address bit
  localparam logic REG_TARGET_CLUSTER = 1'b0;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_QUERY  = 2'd3
  } nct_kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } nct_status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_DRAIN,
    FSM_FINISH
  } nct_fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } nct_cell_op_t;

  typedef struct packed {
    nct_cell_op_t       op;
    logic [SEL_W-1:0]   sel;
  } nct_cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } nct_feed_t;

  typedef struct packed {
    nct_kind_t          kind;
    logic signed [31:0] coord_lat;
    logic signed [31:0] coord_lon;
    logic [5:0]         entry_index;
  } nct_in_t;

  typedef struct packed {
    logic [5:0]  nearest_index;
    logic        is_target;
    nct_status_t status;
    logic [6:0]  centre_count;
  } nct_out_t;

endpackage

>>> sv/nct_cell.sv
// One table cell: holds a centre and loads, shifts or rotates from its neighbour.
module nct_cell #(
  parameter int COORD_BITS = nct_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  nct_pkg::nct_cell_ctl_t       ctl,
  input  logic [nct_pkg::SEL_W-1:0]    cell_pos,
  input  logic [COORD_BITS-1:0]        wr_lat,
  input  logic [COORD_BITS-1:0]        wr_lon,
  input  logic [COORD_BITS-1:0]        nbr_lat,
  input  logic [COORD_BITS-1:0]        nbr_lon,
  output logic [COORD_BITS-1:0]        lat,
  output logic [COORD_BITS-1:0]        lon
);

  logic [COORD_BITS-1:0] lat_r, lat_nxt;
  logic [COORD_BITS-1:0] lon_r, lon_nxt;

  // Pick the next contents of this cell
  always_comb begin
    lat_nxt = lat_r;
    lon_nxt = lon_r;
    case (ctl.op)
      nct_pkg::CELL_LOAD: begin
        if (cell_pos == ctl.sel) begin
          lat_nxt = wr_lat;
          lon_nxt = wr_lon;
        end
      end
      nct_pkg::CELL_SHIFT: begin
        if (cell_pos >= ctl.sel) begin
          lat_nxt = nbr_lat;
          lon_nxt = nbr_lon;
        end
      end
      nct_pkg::CELL_ROTATE: begin
        lat_nxt = nbr_lat;
        lon_nxt = nbr_lon;
      end
      default: begin
        lat_nxt = lat_r;
        lon_nxt = lon_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lat_r <= lat_nxt;
    lon_r <= lon_nxt;
  end

  assign lat = lat_r;
  assign lon = lon_r;

endmodule

>>> sv/nct_dist.sv
// Distance pipeline and running-minimum tracker fed from the head of the cell ring.
module nct_dist #(
  parameter int COORD_BITS = nct_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nct_pkg::nct_feed_t    feed,
  input  logic [IDX_W-1:0]      feed_idx,
  input  logic [COORD_BITS-1:0] cen_lat,
  input  logic [COORD_BITS-1:0] cen_lon,
  input  logic [COORD_BITS-1:0] q_lat,
  input  logic [COORD_BITS-1:0] q_lon,
  output logic [IDX_W-1:0]      best_idx
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;

  logic [COORD_BITS:0]   diff_lat, diff_lon;
  logic [COORD_BITS:0]   neg_lat, neg_lon;
  logic [COORD_BITS-1:0] mag_lat_nxt, mag_lon_nxt;
  logic [COORD_BITS-1:0] mag_lat_r, mag_lon_r;
  logic [IDX_W-1:0]      idx_a_r, idx_b_r, idx_c_r;
  logic                  vld_a_r, vld_b_r, vld_c_r;
  logic [SQ_W-1:0]       sq_lat_nxt, sq_lon_nxt;
  logic [SQ_W-1:0]       sq_lat_r, sq_lon_r;
  logic [DIST_W-1:0]     dist_nxt, dist_r;
  logic [DIST_W-1:0]     best_dist_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic                  best_set_r;
  logic                  take_best;

  // Stage A: signed difference and its magnitude (fits in COORD_BITS bits)
  always_comb begin
    diff_lat    = {cen_lat[COORD_BITS-1], cen_lat} - {q_lat[COORD_BITS-1], q_lat};
    diff_lon    = {cen_lon[COORD_BITS-1], cen_lon} - {q_lon[COORD_BITS-1], q_lon};
    neg_lat     = ~diff_lat + 1'b1;
    neg_lon     = ~diff_lon + 1'b1;
    mag_lat_nxt = diff_lat[COORD_BITS] ? neg_lat[COORD_BITS-1:0] : diff_lat[COORD_BITS-1:0];
    mag_lon_nxt = diff_lon[COORD_BITS] ? neg_lon[COORD_BITS-1:0] : diff_lon[COORD_BITS-1:0];
  end

  // Stage B: one square per coordinate
  always_comb begin
    sq_lat_nxt = {{COORD_BITS{1'b0}}, mag_lat_r} * {{COORD_BITS{1'b0}}, mag_lat_r};
    sq_lon_nxt = {{COORD_BITS{1'b0}}, mag_lon_r} * {{COORD_BITS{1'b0}}, mag_lon_r};
  end

  // Stage C: full-width sum, carry kept
  assign dist_nxt = {1'b0, sq_lat_r} + {1'b0, sq_lon_r};

  // Strict compare keeps the lowest index on a tie, as indices arrive in order
  assign take_best = vld_c_r && (!best_set_r || (dist_r < best_dist_r));

  always_ff @(posedge clk) begin
    mag_lat_r <= mag_lat_nxt;
    mag_lon_r <= mag_lon_nxt;
    idx_a_r   <= feed_idx;
    sq_lat_r  <= sq_lat_nxt;
    sq_lon_r  <= sq_lon_nxt;
    idx_b_r   <= idx_a_r;
    dist_r    <= dist_nxt;
    idx_c_r   <= idx_b_r;
    if (take_best) begin
      best_dist_r <= dist_r;
      best_idx_r  <= idx_c_r;
    end
  end

  // Advance valid flags and restart the minimum at each new query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r    <= 1'b0;
      vld_b_r    <= 1'b0;
      vld_c_r    <= 1'b0;
      best_set_r <= 1'b0;
    end else begin
      vld_a_r <= feed.valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      if (feed.clear) begin
        best_set_r <= 1'b0;
      end else if (take_best) begin
        best_set_r <= 1'b1;
      end
    end
  end

  assign best_idx = best_idx_r;

endmodule

>>> sv/nearest_centre_table_core.sv
// Top level of the nearest-centre table: control, cell ring, distance unit, ports.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------
//  input    | in_valid / in_stall           | in_data  (nct_in_t)
//  result   | out_valid / out_stall         | out_data (nct_out_t)
//  config   | psel penable pwrite pready    | paddr pwdata prdata
//
//  A query rotates the ring of cells once past the single distance unit, then
//  its three-stage pipeline drains. Clear, append and erase go from idle
//  straight to finish. One item is in work at a time; a new item is taken while
//  a result beat waits. rst_n is synchronous and clears count, target and flags;
//  the centre cells are not cleared. A stalled result holds the block in finish.
module nearest_centre_table_core #(
  parameter int MAX_CENTRES = nct_pkg::MAX_CENTRES_DEF,
  parameter int COORD_BITS  = nct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nct_pkg::nct_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nct_pkg::nct_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nct_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nct_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  `include "nearest_centre_table_core_defines.svh"

  localparam int IDX_W = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1;
  localparam int CNT_W = $clog2(MAX_CENTRES + 1);
  localparam int SEL_W = nct_pkg::SEL_W;

  nct_pkg::nct_fsm_t         state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [nct_pkg::TARGET_W-1:0] target_r;
  logic [COORD_BITS-1:0]     q_lat_r, q_lon_r;
  nct_pkg::nct_status_t      res_status_r, res_status_nxt;
  logic                      res_query_r, res_query_nxt;
  logic [IDX_W-1:0]          step_r;
  logic [nct_pkg::DRAIN_W-1:0] drain_r;
  logic                      out_valid_r;
  nct_pkg::nct_out_t         out_data_r, out_data_nxt;

  logic                      in_accept;
  logic                      out_load;
  logic                      cfg_write;
  logic                      step_last;
  logic                      go_run;
  logic [SEL_W-1:0]          count_sel, idx_sel;
  nct_pkg::nct_cell_ctl_t    cell_ctl;
  nct_pkg::nct_feed_t        feed;
  logic [IDX_W-1:0]          best_idx;
  logic                      chk_append, chk_found, chk_hit, chk_stat_ok;

  logic [COORD_BITS-1:0]     cell_lat [MAX_CENTRES];
  logic [COORD_BITS-1:0]     cell_lon [MAX_CENTRES];

  assign in_accept = in_valid && !in_stall;
  assign count_sel = SEL_W'(count_r);
  assign idx_sel   = SEL_W'(in_data.entry_index);
  assign step_last = (step_r == IDX_W'(MAX_CENTRES - 1));
  assign go_run    = (in_data.kind == nct_pkg::KIND_QUERY) && (count_r != '0);

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == nct_pkg::REG_TARGET_CLUSTER)
                     ? nct_pkg::APB_DATA_W'(target_r) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nct_pkg::FSM_IDLE: begin
        if (in_accept) begin
          state_nxt = go_run ? nct_pkg::FSM_RUN : nct_pkg::FSM_FINISH;
        end
      end
      nct_pkg::FSM_RUN: begin
        if (step_last) begin
          state_nxt = nct_pkg::FSM_DRAIN;
        end
      end
      nct_pkg::FSM_DRAIN: begin
        if (drain_r == nct_pkg::DRAIN_LAST) begin
          state_nxt = nct_pkg::FSM_FINISH;
        end
      end
      nct_pkg::FSM_FINISH: begin
        if (out_load) begin
          state_nxt = nct_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = nct_pkg::FSM_IDLE;
    endcase
  end

  // Outputs of the state machine: stall, ring control, feed, result load
  always_comb begin
    in_stall     = 1'b1;
    cell_ctl.op  = nct_pkg::CELL_HOLD;
    cell_ctl.sel = count_sel;
    feed.valid   = 1'b0;
    feed.clear   = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      nct_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_data.kind)
            nct_pkg::KIND_APPEND: begin
              if (count_r < CNT_W'(MAX_CENTRES)) begin
                cell_ctl.op = nct_pkg::CELL_LOAD;
              end
            end
            nct_pkg::KIND_ERASE: begin
              if (count_r != '0 && idx_sel < count_sel) begin
                cell_ctl.op  = nct_pkg::CELL_SHIFT;
                cell_ctl.sel = idx_sel;
              end
            end
            nct_pkg::KIND_QUERY: feed.clear = 1'b1;
            default: cell_ctl.op = nct_pkg::CELL_HOLD;
          endcase
        end
      end
      nct_pkg::FSM_RUN: begin
        cell_ctl.op = nct_pkg::CELL_ROTATE;
        feed.valid  = (SEL_W'(step_r) < count_sel);
      end
      nct_pkg::FSM_DRAIN: begin
        in_stall = 1'b1;
      end
      nct_pkg::FSM_FINISH: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Decide status and new count when an item is taken
  always_comb begin
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_query_nxt  = res_query_r;
    if (in_accept) begin
      res_status_nxt = nct_pkg::STAT_OK;
      res_query_nxt  = go_run;
      case (in_data.kind)
        nct_pkg::KIND_CLEAR: count_nxt = '0;
        nct_pkg::KIND_APPEND: begin
          if (count_r < CNT_W'(MAX_CENTRES)) begin
            count_nxt = count_r + 1'b1;
          end else begin
            res_status_nxt = nct_pkg::STAT_FULL;
          end
        end
        nct_pkg::KIND_ERASE: begin
          if (count_r == '0) begin
            res_status_nxt = nct_pkg::STAT_EMPTY;
          end else if (idx_sel >= count_sel) begin
            res_status_nxt = nct_pkg::STAT_RANGE;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        nct_pkg::KIND_QUERY: begin
          if (count_r == '0) begin
            res_status_nxt = nct_pkg::STAT_EMPTY;
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  // Build the result beat
  always_comb begin
    out_data_nxt.status       = res_status_r;
    out_data_nxt.centre_count = 7'(count_r);
    out_data_nxt.nearest_index = res_query_r ? 6'(best_idx) : 6'd0;
    out_data_nxt.is_target    = res_query_r &&
                                (SEL_W'(best_idx) == SEL_W'(target_r));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nct_pkg::FSM_IDLE;
      count_r     <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
      res_query_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_query_r <= res_query_nxt;
      if (cfg_write && paddr[2] == nct_pkg::REG_TARGET_CLUSTER) begin
        target_r <= pwdata[nct_pkg::TARGET_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and sequencing registers
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    if (in_accept) begin
      q_lat_r <= in_data.coord_lat[COORD_BITS-1:0];
      q_lon_r <= in_data.coord_lon[COORD_BITS-1:0];
      step_r  <= '0;
    end else if (state_r == nct_pkg::FSM_RUN) begin
      step_r  <= step_r + 1'b1;
    end
    if (state_r == nct_pkg::FSM_RUN) begin
      drain_r <= '0;
    end else if (state_r == nct_pkg::FSM_DRAIN) begin
      drain_r <= drain_r + 1'b1;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Ring of cells; cell 0 is the head seen by the distance unit
  for (genvar g = 0; g < MAX_CENTRES; g++) begin : g_cell
    nct_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .cell_pos (SEL_W'(g)),
      .wr_lat   (in_data.coord_lat[COORD_BITS-1:0]),
      .wr_lon   (in_data.coord_lon[COORD_BITS-1:0]),
      .nbr_lat  (cell_lat[(g + 1) % MAX_CENTRES]),
      .nbr_lon  (cell_lon[(g + 1) % MAX_CENTRES]),
      .lat      (cell_lat[g]),
      .lon      (cell_lon[g])
    );
  end

  nct_dist #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .feed     (feed),
    .feed_idx (step_r),
    .cen_lat  (cell_lat[0]),
    .cen_lon  (cell_lon[0]),
    .q_lat    (q_lat_r),
    .q_lon    (q_lon_r),
    .best_idx (best_idx)
  );

  // Checks
  assign chk_append  = in_accept && (in_data.kind == nct_pkg::KIND_APPEND) &&
                       (count_r < CNT_W'(MAX_CENTRES));
  assign chk_found   = (state_r == nct_pkg::FSM_FINISH) && res_query_r;
  assign chk_hit     = out_valid && out_data.is_target;
  assign chk_stat_ok = (out_data.status == nct_pkg::STAT_OK);

  `NCT_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(MAX_CENTRES), "table count overflow")
  `NCT_ASSERT_IMPL(a_target_ok, chk_hit, chk_stat_ok, "target flag on failed item")
  `NCT_ASSERT_IMPL(a_best_in_table, chk_found, SEL_W'(best_idx) < count_sel, "index beyond table")
  `NCT_ASSERT_NEXT(a_append_grows, chk_append, count_r == $past(count_r) + 1'b1, "append lost")

endmodule

>>> bench/nearest_centre_table_core_tb.sv
// Self-checking testbench for the nearest-centre table core.
module nearest_centre_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nct_pkg::*;

  localparam int TABLE_DEPTH = MAX_CENTRES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int END_SETTLE  = 80;
  localparam logic [APB_ADDR_W-1:0] TARGET_ADDR = {REG_TARGET_CLUSTER, 2'b00};
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  nct_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  nct_out_t              out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predicted table contents and register
  logic signed [31:0] lat_store [TABLE_DEPTH];
  logic signed [31:0] lon_store [TABLE_DEPTH];
  int                 live_count = 0;
  logic [5:0]         target_sel = '0;
  nct_out_t           pending_results [$];

  int errors_seen  = 0;
  int quiet_cycles = 0;
  int burst_left   = 0;
  int stall_mode   = STALL_NONE;
  int stall_left   = 0;

  nearest_centre_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors_seen++;
    $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Squared difference of two coordinates, exact at 64 bits
  function automatic logic [63:0] sq_gap(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic [32:0] d;
    logic [32:0] absd;
    logic [63:0] mag;
    d    = {a[31], a} - {b[31], b};
    absd = d[32] ? -d : d;
    mag  = {31'd0, absd};
    return mag * mag;
  endfunction

  // Apply one item to the predicted table and return its result
  function automatic nct_out_t apply_table_item(input nct_in_t item);
    nct_out_t    res;
    logic [64:0] gap_sum;
    logic [64:0] best;
    int          best_k;
    int          k;
    res    = '0;
    best   = '0;
    best_k = 0;
    case (item.kind)
      KIND_CLEAR: begin
        live_count = 0;
      end
      KIND_APPEND: begin
        if (live_count >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          lat_store[live_count] = item.coord_lat;
          lon_store[live_count] = item.coord_lon;
          live_count++;
        end
      end
      KIND_ERASE: begin
        if (live_count == 0) begin
          res.status = STAT_EMPTY;
        end else if (int'(item.entry_index) >= live_count) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = int'(item.entry_index); k + 1 < live_count; k++) begin
            lat_store[k] = lat_store[k + 1];
            lon_store[k] = lon_store[k + 1];
          end
          live_count--;
        end
      end
      default: begin
        if (live_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // Lowest index wins a tie: only a strictly smaller distance replaces
          for (k = 0; k < live_count; k++) begin
            gap_sum = {1'b0, sq_gap(lat_store[k], item.coord_lat)} +
                      {1'b0, sq_gap(lon_store[k], item.coord_lon)};
            if (k == 0 || gap_sum < best) begin
              best   = gap_sum;
              best_k = k;
            end
          end
          res.nearest_index = best_k[5:0];
          res.is_target     = (best_k[5:0] == target_sel);
        end
      end
    endcase
    res.centre_count = live_count[6:0];
    return res;
  endfunction

  // Predict on accepted input beats, compare accepted result beats
  always @(posedge clk) begin : result_check
    nct_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        pending_results = {pending_results, apply_table_item(in_data)};
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, centre_count",
                          out_data.centre_count, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_data.nearest_index !== want.nearest_index)
            report_mismatch("nearest_index", out_data.nearest_index, want.nearest_index);
          if (out_data.is_target !== want.is_target)
            report_mismatch("is_target", out_data.is_target, want.is_target);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.centre_count !== want.centre_count)
            report_mismatch("centre_count", out_data.centre_count, want.centre_count);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure: stretches of no, light and heavy stalling
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      default:     out_stall <= ($urandom_range(0, 99) < 80);
    endcase
  end

  // Send one beat; called and returns at a falling edge
  task automatic send_item(input nct_kind_t kind, input logic signed [31:0] lat,
                           input logic signed [31:0] lon, input logic [5:0] idx);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, coord_lat: lat, coord_lon: lon, entry_index: idx};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold the sender until every pending result has arrived
  task automatic settle_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the target register, then read it back
  task automatic write_target(input logic [5:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= {26'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    target_sel = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, value}) report_mismatch("target_cluster readback", prdata, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Coordinates: fully random, clustered near a few hubs, extremes, or near zero
  function automatic logic signed [31:0] pick_coord();
    int unsigned r;
    logic signed [31:0] hub;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       hub = 32'sh0000_0000;
      1:       hub = 32'sh1000_0000;
      2:       hub = -32'sh2000_0000;
      default: hub = 32'sh0123_4567;
    endcase
    if (r < 40) return $urandom;
    if (r < 80) return hub + $signed($urandom_range(0, 255)) - 128;
    if (r < 90) return ($urandom_range(0, 1) == 0) ? COORD_MAX : COORD_MIN;
    return $signed($urandom_range(0, 32)) - 16;
  endfunction

  task automatic send_random_item();
    int unsigned r;
    nct_kind_t   kind;
    logic [5:0]  idx;
    r = $urandom_range(0, 99);
    if (r < 2)       kind = KIND_CLEAR;
    else if (r < 40) kind = KIND_APPEND;
    else if (r < 57) kind = KIND_ERASE;
    else             kind = KIND_QUERY;
    // Mostly valid erase positions, some beyond the count
    if ($urandom_range(0, 9) < 7 && live_count > 0) idx = $urandom_range(0, live_count - 1);
    else idx = $urandom_range(0, 63);
    send_item(kind, pick_coord(), pick_coord(), idx);
  endtask

  // Empty table: query and erase flag it, clear is harmless
  task automatic test_empty_table();
    send_item(KIND_QUERY, COORD_MAX, COORD_MIN, 6'd0);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd0);
    send_item(KIND_CLEAR, COORD_MIN, COORD_MAX, 6'd63);
    send_item(KIND_QUERY, 32'sd0, 32'sd0, 6'd63);
  endtask

  // Extreme coordinates, carry into the 65th distance bit, ties and erase bounds
  task automatic test_extremes();
    send_item(KIND_APPEND, COORD_MAX, COORD_MAX, 6'd63);
    send_item(KIND_APPEND, COORD_MIN, COORD_MIN, 6'd0);
    send_item(KIND_APPEND, 32'sd0, 32'sd0, 6'd21);
    send_item(KIND_APPEND, COORD_MAX, COORD_MIN, 6'd42);
    send_item(KIND_APPEND, 32'sd0, 32'sd0, 6'd5);
    send_item(KIND_QUERY, COORD_MIN, COORD_MAX, 6'd0);
    send_item(KIND_QUERY, COORD_MAX, COORD_MAX, 6'd0);
    send_item(KIND_QUERY, COORD_MIN, COORD_MIN, 6'd0);
    send_item(KIND_QUERY, 32'sd0, 32'sd0, 6'd0);
    send_item(KIND_QUERY, 32'sd1, -32'sd1, 6'd0);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd5);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd63);
    send_item(KIND_ERASE, COORD_MAX, COORD_MAX, 6'd1);
    send_item(KIND_QUERY, COORD_MIN, COORD_MIN, 6'd0);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd3);
    send_item(KIND_QUERY, COORD_MAX, COORD_MIN, 6'd0);
    send_item(KIND_CLEAR, 32'sd0, 32'sd0, 6'd0);
    send_item(KIND_QUERY, COORD_MAX, COORD_MIN, 6'd0);
  endtask

  // Target flag follows the register
  task automatic test_target_register();
    settle_table();
    write_target(6'd2);
    send_item(KIND_APPEND, 32'sd100, 32'sd100, 6'd0);
    send_item(KIND_APPEND, -32'sd100, 32'sd100, 6'd0);
    send_item(KIND_APPEND, 32'sd100, -32'sd100, 6'd0);
    send_item(KIND_QUERY, 32'sd90, -32'sd90, 6'd0);
    send_item(KIND_QUERY, 32'sd90, 32'sd90, 6'd0);
    settle_table();
    write_target(6'd0);
    send_item(KIND_QUERY, 32'sd90, 32'sd90, 6'd0);
  endtask

  // Fill to capacity, overflow, hit the last slot, erase at both ends
  task automatic test_full_table();
    int i;
    settle_table();
    write_target(6'd63);
    send_item(KIND_CLEAR, 32'sd0, 32'sd0, 6'd0);
    for (i = 0; i < TABLE_DEPTH; i++)
      send_item(KIND_APPEND, 32'(i) <<< 25, -(32'(i) <<< 25), 6'($urandom_range(0, 63)));
    send_item(KIND_APPEND, COORD_MAX, COORD_MAX, 6'd0);
    send_item(KIND_QUERY, 32'(63) <<< 25, -(32'(63) <<< 25), 6'd0);
    send_item(KIND_QUERY, 32'sd0, 32'sd0, 6'd0);
    send_item(KIND_QUERY, COORD_MIN, COORD_MAX, 6'd0);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd63);
    send_item(KIND_ERASE, 32'sd0, 32'sd0, 6'd0);
    send_item(KIND_QUERY, 32'(63) <<< 25, -(32'(63) <<< 25), 6'd0);
    send_item(KIND_APPEND, 32'(63) <<< 25, -(32'(63) <<< 25), 6'd0);
    send_item(KIND_QUERY, COORD_MAX, COORD_MIN, 6'd0);
  endtask

  // Random traffic in phases, each with its own target setting
  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < 5; phase++) begin
      settle_table();
      case (phase)
        0:       write_target(6'd63);
        1:       write_target(6'd0);
        2:       write_target(6'($urandom_range(1, 7)));
        3:       write_target(6'($urandom_range(0, 63)));
        default: write_target(6'd3);
      endcase
      for (n = 0; n < 170; n++) send_random_item();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_table();
    test_extremes();
    test_target_register();
    test_full_table();
    test_random_traffic();
    settle_table();
    repeat (END_SETTLE) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (errors_seen == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
